// ===== hw/rtl/text_lcd_cursor_writer_assert.svh =====
// assertion macros for the rtl files, included by tlcd_nibble_out
// each assertion is clocked on clk and held off while rst_n is low
`ifndef TEXT_LCD_CURSOR_WRITER_ASSERT_SVH
`define TEXT_LCD_CURSOR_WRITER_ASSERT_SVH

`ifndef SYNTH
`define TLCD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlcd assertion failed");
`define TLCD_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tlcd forbidden condition seen");
`else
`define TLCD_ASSERT(lbl, prop)
`define TLCD_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== hw/rtl/tlcd_pkg.sv =====
package tlcd_pkg;

    // field widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 5;
    localparam int ROW_W    = 2;
    localparam int PANEL_W  = 2;
    localparam int NIB_W    = 4;

    // action codes
    localparam logic [ACTION_W-1:0] ACTION_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACTION_MOVE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACTION_CLEAR = 2'd2;

    // panel types
    localparam logic [PANEL_W-1:0] PANEL_16X2     = 2'd0;
    localparam logic [PANEL_W-1:0] PANEL_16X2_ALT = 2'd1;
    localparam logic [PANEL_W-1:0] PANEL_20X2     = 2'd2;
    localparam logic [PANEL_W-1:0] PANEL_20X4     = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
    localparam logic [CHAR_W-1:0] CMD_CLEAR    = 8'h01;

    // one input word
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_code;
        logic [COL_W-1:0]    target_column;
        logic [ROW_W-1:0]    target_row;
    } item_t;

    // bytes to be sent for one word
    typedef struct packed {
        logic              emits;
        logic              two_only;
        logic [CHAR_W-1:0] first_byte;
        logic [CHAR_W-1:0] second_byte;
    } packet_t;

    // panel width in columns
    function automatic logic [COL_W-1:0] panel_columns(input logic [PANEL_W-1:0] ptype);
        logic [COL_W-1:0] n;
        n = 5'd16;
        if (ptype == PANEL_20X2 || ptype == PANEL_20X4)
        begin
            n = 5'd20;
        end
        return n;
    endfunction

    // panel height in rows
    function automatic logic [ROW_W:0] panel_rows(input logic [PANEL_W-1:0] ptype);
        logic [ROW_W:0] n;
        n = 3'd2;
        if (ptype == PANEL_20X4)
        begin
            n = 3'd4;
        end
        return n;
    endfunction

    // set-address command for column zero of a row, modulo 256
    function automatic logic [CHAR_W-1:0] row_base(input logic [PANEL_W-1:0] ptype,
                                                  input logic [ROW_W-1:0]   row);
        logic [CHAR_W-1:0] b;
        b = 8'h80;
        unique case (ptype) inside
            PANEL_20X4:
            begin
                unique case (row)
                    2'd0: b = 8'h80;
                    2'd1: b = 8'hc0;
                    2'd2: b = 8'h94;
                    2'd3: b = 8'hd4;
                    default: b = 8'h80;
                endcase
            end
            PANEL_16X2_ALT:
            begin
                // row stride of 40
                unique case (row)
                    2'd0: b = 8'h80;
                    2'd1: b = 8'ha8;
                    2'd2: b = 8'hd0;
                    2'd3: b = 8'hf8;
                    default: b = 8'h80;
                endcase
            end
            PANEL_16X2, PANEL_20X2:
            begin
                // row stride of 0x40
                unique case (row)
                    2'd0: b = 8'h80;
                    2'd1: b = 8'hc0;
                    2'd2: b = 8'h00;
                    2'd3: b = 8'h40;
                    default: b = 8'h80;
                endcase
            end
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/tlcd_cursor.sv =====
module tlcd_cursor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [tlcd_pkg::PANEL_W-1:0]    cfg_write_data,
    input  tlcd_pkg::item_t                 item,
    input  logic                            fire,
    output tlcd_pkg::packet_t               packet
);
    import tlcd_pkg::*;

    logic [PANEL_W-1:0] panel_type_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;

    logic [COL_W-1:0]   ncols;
    logic [ROW_W:0]     nrows;
    logic [ROW_W:0]     rows_m1;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [ROW_W-1:0]   row_wrap;
    logic [CHAR_W-1:0]  addr;
    logic               is_newline;

    // panel geometry
    assign ncols   = panel_columns(panel_type_reg);
    assign nrows   = panel_rows(panel_type_reg);
    assign rows_m1 = nrows - 3'd1;

    // cursor stepping
    assign col_inc    = {1'b0, col_reg} + 6'd1;
    assign row_inc    = {1'b0, row_reg} + 3'd1;
    assign row_wrap   = (row_inc >= nrows) ? '0 : row_inc[ROW_W-1:0];
    assign addr       = row_base(panel_type_reg, row_reg) + {3'b000, col_reg};
    assign is_newline = (item.char_code == NEWLINE_CODE);

    // next cursor and outgoing bytes
    always_comb
    begin
        col_next           = col_reg;
        row_next           = row_reg;
        packet.emits       = 1'b0;
        packet.two_only    = 1'b0;
        packet.first_byte  = addr;
        packet.second_byte = item.char_code;
        case (item.action)
            ACTION_PUT:
            begin
                if (is_newline)
                begin
                    col_next = '0;
                    row_next = row_wrap;
                end
                else
                begin
                    packet.emits = 1'b1;
                    if (col_inc >= {1'b0, ncols})
                    begin
                        col_next = '0;
                        row_next = row_wrap;
                    end
                    else
                    begin
                        col_next = col_inc[COL_W-1:0];
                    end
                end
            end
            ACTION_MOVE:
            begin
                col_next = (item.target_column >= ncols) ? ncols - 5'd1 : item.target_column;
                row_next = ({1'b0, item.target_row} >= nrows) ? rows_m1[ROW_W-1:0]
                                                              : item.target_row;
            end
            ACTION_CLEAR:
            begin
                packet.emits      = 1'b1;
                packet.two_only   = 1'b1;
                packet.first_byte = CMD_CLEAR;
                col_next          = '0;
                row_next          = '0;
            end
            default:
            begin
                col_next = col_reg;
                row_next = row_reg;
            end
        endcase
    end

    // cursor and panel registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_type_reg <= PANEL_16X2;
            col_reg        <= '0;
            row_reg        <= '0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                panel_type_reg <= cfg_write_data;
            end
            if (fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

// ===== hw/rtl/tlcd_nibble_out.sv =====
`include "text_lcd_cursor_writer_assert.svh"

module tlcd_nibble_out (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  tlcd_pkg::packet_t            packet,
    output logic                         can_load,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         register_select,
    output logic [tlcd_pkg::NIB_W-1:0]   nibble,
    output logic                         long_wait,
    output logic                         last
);
    import tlcd_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic              two_only_reg;
    logic [CHAR_W-1:0] first_reg;
    logic [CHAR_W-1:0] second_reg;
    logic [1:0]        final_idx;
    logic [CHAR_W-1:0] cur_byte;
    logic              is_last;
    logic              done;

    // nibble selection: bytes in order, high half first
    assign final_idx       = two_only_reg ? 2'd1 : 2'd3;
    assign is_last         = (idx_reg == final_idx);
    assign cur_byte        = idx_reg[1] ? second_reg : first_reg;
    assign nibble          = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
    assign register_select = idx_reg[1];
    assign long_wait       = two_only_reg && is_last;
    assign last            = is_last;
    assign out_valid       = busy_reg;

    // a new word may enter as the final nibble leaves
    assign done     = busy_reg && out_ready && is_last;
    assign can_load = !busy_reg || done;

    // sequencer next state
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg && out_ready)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // byte holding registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            two_only_reg <= packet.two_only;
            first_reg    <= packet.first_byte;
            second_reg   <= packet.second_byte;
        end
    end

    // checks
    `TLCD_ASSERT(a_clear_short, (busy_reg && two_only_reg) |-> !idx_reg[1])
    `TLCD_ASSERT(a_wait_on_last, (busy_reg && long_wait) |-> last)
    `TLCD_ASSERT(a_data_not_clear, (busy_reg && register_select) |-> !two_only_reg)
    `TLCD_ASSERT(a_drain_idle, (done && !load) |=> !busy_reg)
    `TLCD_ASSERT_NEVER(a_load_when_busy, load && !can_load)

endmodule

// ===== hw/rtl/text_lcd_cursor_writer.sv =====
// Character panel writer, 4-bit bus form.
// Input channel (in_valid/in_ready): one word carries action, char_code,
// target_column and target_row. Put sends a set-address byte then the data
// byte, clear sends the clear command, move and newline only shift the cursor.
// Output channel (out_valid/out_ready): one nibble per word, high half first,
// with register_select, long_wait on the final nibble of a clear, and last on
// the final nibble of each input word.
// Configuration: cfg_write_enable writes cfg_write_data into panel_type at once.
// With the sequencer free, a taken input word moves from the input register into
// the sequencer's byte registers, and its first nibble is then on the output.
// Output use: a put sends four nibbles, a clear two; the nibble
// sequencer is the limit and loads the next word as the final nibble leaves.
// Words without output (move, newline, unused action) pass at one per cycle.
// Reset: cursor at column 0 row 0, panel_type 0, both channels empty.
// Output stall: the current nibble holds; one further input word waits in the
// input register, after which in_ready falls.
module text_lcd_cursor_writer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_enable,
    input  logic [tlcd_pkg::PANEL_W-1:0]    cfg_write_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tlcd_pkg::ACTION_W-1:0]   action,
    input  logic [tlcd_pkg::CHAR_W-1:0]     char_code,
    input  logic [tlcd_pkg::COL_W-1:0]      target_column,
    input  logic [tlcd_pkg::ROW_W-1:0]      target_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            register_select,
    output logic [tlcd_pkg::NIB_W-1:0]      nibble,
    output logic                            long_wait,
    output logic                            last
);
    import tlcd_pkg::*;

    logic     in_full_reg;
    logic     in_full_next;
    item_t    item_reg;
    packet_t  packet;
    logic     can_load;
    logic     advance;
    logic     accept;

    // input register handshake
    assign advance      = in_full_reg && (!packet.emits || can_load);
    assign in_ready     = !in_full_reg || advance;
    assign accept       = in_valid && in_ready;
    assign in_full_next = accept || (in_full_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action        <= action;
            item_reg.char_code     <= char_code;
            item_reg.target_column <= target_column;
            item_reg.target_row    <= target_row;
        end
    end

    // cursor tracking and byte build
    tlcd_cursor u_cursor (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .item             (item_reg),
        .fire             (advance),
        .packet           (packet)
    );

    // nibble sequencer and output register
    tlcd_nibble_out u_nibble_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (advance && packet.emits),
        .packet          (packet),
        .can_load        (can_load),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .register_select (register_select),
        .nibble          (nibble),
        .long_wait       (long_wait),
        .last            (last)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import tlcd_pkg::*;

    // code that the block must ignore
    localparam logic [ACTION_W-1:0] ACTION_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;

    // one nibble transfer on the panel bus
    typedef struct packed {
        logic             rs;
        logic [NIB_W-1:0] nib;
        logic             lw;
        logic             fin;
    } bus_nibble_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_enable;
    logic [PANEL_W-1:0]  cfg_write_data;
    logic                in_valid;
    logic                in_ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [COL_W-1:0]    target_column;
    logic [ROW_W-1:0]    target_row;
    logic                out_valid;
    logic                out_ready;
    logic                register_select;
    logic [NIB_W-1:0]    nibble;
    logic                long_wait;
    logic                last;

    // cursor and panel state mirrored by the predictor
    logic [COL_W-1:0]    cursor_col;
    logic [ROW_W-1:0]    cursor_row;
    logic [PANEL_W-1:0]  panel_sel;

    bus_nibble_t         due_nibbles[$];
    int                  send_idle_pct;
    int                  stall_pct;
    int                  hold_cycles;
    int                  bad_count;

    text_lcd_cursor_writer DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .char_code        (char_code),
        .target_column    (target_column),
        .target_row       (target_row),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .register_select  (register_select),
        .nibble           (nibble),
        .long_wait        (long_wait),
        .last             (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // overall time limit
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // compare each delivered word with the oldest expected nibble
    initial
    begin
        bus_nibble_t want;
        bus_nibble_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{register_select, nibble, long_wait, last};
                if (due_nibbles.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected word: rs=%0d nib=%h lw=%0d last=%0d",
                                 got.rs, got.nib, got.lw, got.fin);
                end
                else
                begin
                    want = due_nibbles.pop_front();
                    if (got != want)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"mismatch: expected rs=%0d nib=%h lw=%0d last=%0d,",
                                      " got rs=%0d nib=%h lw=%0d last=%0d"},
                                     want.rs, want.nib, want.lw, want.fin,
                                     got.rs, got.nib, got.lw, got.fin);
                    end
                end
            end
        end
    end

    // wrap to the first row past the bottom of the panel
    function automatic logic [ROW_W-1:0] row_after(input logic [ROW_W-1:0] row,
                                                   input logic [ROW_W:0]   nrows);
        logic [ROW_W:0] r;
        r = {1'b0, row} + 3'd1;
        if (r >= nrows)
            r = '0;
        return r[ROW_W-1:0];
    endfunction

    // cursor update and nibbles expected for one accepted word
    task automatic predict_bus_nibbles(input item_t w);
        logic [COL_W-1:0] ncols;
        logic [ROW_W:0]   nrows;
        logic [CHAR_W-1:0] addr;
        logic [COL_W:0]   col_next;
        ncols = (panel_sel == PANEL_20X2 || panel_sel == PANEL_20X4) ? 5'd20 : 5'd16;
        nrows = (panel_sel == PANEL_20X4) ? 3'd4 : 3'd2;
        case (w.action)
            ACTION_PUT:
            begin
                if (w.char_code == NEWLINE_CODE)
                begin
                    cursor_col = '0;
                    cursor_row = row_after(cursor_row, nrows);
                end
                else
                begin
                    // set-address byte, modulo 256
                    if (panel_sel == PANEL_20X4)
                    begin
                        case (cursor_row)
                            2'd0: addr = 8'h80;
                            2'd1: addr = 8'hc0;
                            2'd2: addr = 8'h94;
                            default: addr = 8'hd4;
                        endcase
                    end
                    else if (panel_sel == PANEL_16X2_ALT)
                        addr = 8'h80 + {6'd0, cursor_row} * 8'd40;
                    else
                        addr = 8'h80 + {6'd0, cursor_row} * 8'h40;
                    addr = addr + {3'd0, cursor_col};
                    due_nibbles.push_back('{1'b0, addr[7:4], 1'b0, 1'b0});
                    due_nibbles.push_back('{1'b0, addr[3:0], 1'b0, 1'b0});
                    due_nibbles.push_back('{1'b1, w.char_code[7:4], 1'b0, 1'b0});
                    due_nibbles.push_back('{1'b1, w.char_code[3:0], 1'b0, 1'b1});
                    col_next = {1'b0, cursor_col} + 6'd1;
                    if (col_next >= {1'b0, ncols})
                    begin
                        col_next = '0;
                        cursor_row = row_after(cursor_row, nrows);
                    end
                    cursor_col = col_next[COL_W-1:0];
                end
            end
            ACTION_MOVE:
            begin
                // saturate to the last column and row
                cursor_col = (w.target_column >= ncols) ? ncols - 5'd1 : w.target_column;
                cursor_row = ({1'b0, w.target_row} >= nrows) ? ROW_W'(nrows - 3'd1)
                                                             : w.target_row;
            end
            ACTION_CLEAR:
            begin
                due_nibbles.push_back('{1'b0, CMD_CLEAR[7:4], 1'b0, 1'b0});
                due_nibbles.push_back('{1'b0, CMD_CLEAR[3:0], 1'b1, 1'b1});
                cursor_col = '0;
                cursor_row = '0;
            end
            default:
            begin
                // unused code, nothing happens
            end
        endcase
    endtask

    function automatic item_t make_word(input logic [ACTION_W-1:0] act,
                                        input logic [CHAR_W-1:0]   ch,
                                        input logic [COL_W-1:0]    col,
                                        input logic [ROW_W-1:0]    row);
        item_t w;
        w.action        = act;
        w.char_code     = ch;
        w.target_column = col;
        w.target_row    = row;
        return w;
    endfunction

    // mostly characters, with moves, clears and some ignored codes
    function automatic item_t random_word();
        int               pick;
        logic [CHAR_W-1:0] ch;
        logic [ACTION_W-1:0] act;
        pick = $urandom_range(99);
        ch   = CHAR_W'($urandom_range(255));
        if (pick < 60)
        begin
            act = ACTION_PUT;
            if ($urandom_range(9) == 0)
                ch = NEWLINE_CODE;
        end
        else if (pick < 78)
            act = ACTION_MOVE;
        else if (pick < 92)
            act = ACTION_CLEAR;
        else
            act = ACTION_UNUSED;
        return make_word(act, ch, COL_W'($urandom_range(31)), ROW_W'($urandom_range(3)));
    endfunction

    // offer one word, hold it until taken, then predict
    task automatic send_word(input item_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= w.action;
        char_code     <= w.char_code;
        target_column <= w.target_column;
        target_row    <= w.target_row;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_bus_nibbles(w);
    endtask

    // sender pauses until every expected nibble is out and the block has settled
    task automatic wait_all_delivered();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_nibbles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_panel(input logic [PANEL_W-1:0] p);
        wait_all_delivered();
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= p;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        panel_sel = p;
    endtask

    // character extremes and newline on the reset panel
    task automatic test_put_extremes();
        send_word(make_word(ACTION_PUT, 8'h00, 5'd0, 2'd0));
        send_word(make_word(ACTION_PUT, 8'hff, 5'd31, 2'd3));
        send_word(make_word(ACTION_PUT, 8'h5a, 5'd10, 2'd1));
        send_word(make_word(ACTION_PUT, NEWLINE_CODE, 5'd0, 2'd0));
        send_word(make_word(ACTION_PUT, 8'ha5, 5'd21, 2'd2));
    endtask

    // saturating moves, wrap at end of row and panel, ignored code
    task automatic test_cursor_moves();
        send_word(make_word(ACTION_MOVE, 8'h00, 5'd31, 2'd3));
        send_word(make_word(ACTION_PUT, 8'h41, 5'd0, 2'd0));
        send_word(make_word(ACTION_MOVE, 8'hff, 5'd15, 2'd0));
        send_word(make_word(ACTION_PUT, 8'h42, 5'd0, 2'd0));
        send_word(make_word(ACTION_UNUSED, 8'hff, 5'd31, 2'd3));
        send_word(make_word(ACTION_PUT, 8'h43, 5'd0, 2'd0));
    endtask

    task automatic test_clear();
        send_word(make_word(ACTION_MOVE, 8'h00, 5'd7, 2'd1));
        send_word(make_word(ACTION_CLEAR, 8'hff, 5'd31, 2'd3));
        send_word(make_word(ACTION_PUT, 8'h30, 5'd0, 2'd0));
    endtask

    // cursor left outside a smaller panel after a type change
    task automatic test_panel_shrink();
        write_panel(PANEL_20X4);
        send_word(make_word(ACTION_MOVE, 8'h00, 5'd19, 2'd3));
        send_word(make_word(ACTION_PUT, 8'h7e, 5'd0, 2'd0));
        send_word(make_word(ACTION_MOVE, 8'h00, 5'd18, 2'd3));
        write_panel(PANEL_16X2_ALT);
        send_word(make_word(ACTION_PUT, 8'h21, 5'd0, 2'd0));
        send_word(make_word(ACTION_MOVE, 8'h00, 5'd19, 2'd2));
        write_panel(PANEL_16X2);
        send_word(make_word(ACTION_PUT, 8'h22, 5'd0, 2'd0));
    endtask

    // receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 120;
        repeat (12)
            send_word(make_word(ACTION_PUT, CHAR_W'($urandom_range(255)),
                                COL_W'($urandom_range(31)), ROW_W'($urandom_range(3))));
        wait_all_delivered();
    endtask

    task automatic test_random_traffic(input int count, input logic [PANEL_W-1:0] p,
                                       input int idle, input int stall);
        write_panel(p);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int i = 0; i < count; i++)
        begin
            send_word(random_word());
            if (i == count / 2)
                wait_all_delivered();
        end
    endtask

    // main sequence
    initial
    begin
        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_write_data   <= '0;
        in_valid         <= 1'b0;
        action           <= ACTION_PUT;
        char_code        <= '0;
        target_column    <= '0;
        target_row       <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        bad_count     = 0;
        cursor_col    = '0;
        cursor_row    = '0;
        panel_sel     = PANEL_16X2;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_put_extremes();
        test_cursor_moves();
        test_clear();
        test_panel_shrink();
        test_backpressure();
        test_random_traffic(38, PANEL_16X2, 0, 0);
        test_random_traffic(38, PANEL_20X4, 81, 0);
        test_random_traffic(38, PANEL_16X2_ALT, 0, 81);
        test_random_traffic(38, PANEL_20X2, 22, 22);
        test_random_traffic(38, PANEL_20X4, 0, 0);

        wait_all_delivered();
        repeat (10) @(posedge clk);
        if (bad_count == 0 && due_nibbles.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tlcd_pkg.sv
hw/rtl/tlcd_cursor.sv
hw/rtl/tlcd_nibble_out.sv
hw/rtl/text_lcd_cursor_writer.sv
tb/sv/tb_top.sv
